[hw/rtl/cmprf_pkg.sv]
// Package for the confusion-matrix metrics block: FSM state type and fixed widths.
// No dependencies.
package cmprf_pkg;

	localparam int NUM_CLASSES_W = 7;
	localparam int ENTRY_W       = 24;
	localparam int CLASS_W       = 6;
	localparam int METRIC_W      = 17;

	typedef enum logic [4:0] {
		ST_LOAD  = 5'b00001,
		ST_RD    = 5'b00010,
		ST_DIV   = 5'b00100,
		ST_OUT   = 5'b01000,
		ST_CLR   = 5'b10000
	} state_t;

endpackage

[hw/rtl/cmprf_divider.sv]
// Restoring divider, one quotient bit per cycle, for the metric fractions.
// Depends on nothing beyond its parameters.
module cmprf_divider #(
	parameter int NUM_W = 34,
	parameter int DEN_W = 31,
	parameter int Q_W   = 17
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             go,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             done,
	output logic [Q_W-1:0]   quot
);

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic [NUM_W-1:0] num_q;
	logic [DEN_W-1:0] den_q;
	logic [DEN_W:0]   rem_q;
	logic [NUM_W-1:0] quo_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic [DEN_W+1:0] trial;
	logic [DEN_W+1:0] shifted;

	// One shift-subtract step on the partial remainder.
	always_comb begin
		shifted = {rem_q, num_q[NUM_W-1]};
		trial   = shifted - {2'b00, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (go) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			num_q <= num_q << 1;
			if (!trial[DEN_W+1]) begin
				rem_q <= trial[DEN_W:0];
				quo_q <= {quo_q[NUM_W-2:0], 1'b1};
			end else begin
				rem_q <= shifted[DEN_W:0];
				quo_q <= {quo_q[NUM_W-2:0], 1'b0};
			end
		end
	end

	// A zero divisor yields zero.
	assign quot = (den_q == '0) ? '0 : quo_q[Q_W-1:0];

endmodule

[hw/rtl/confusion_matrix_prf_metrics.sv]
// Top level of the confusion-matrix metrics block: load FSM, totals memory, dividers.
// Depends on cmprf_pkg and cmprf_divider.
//
// Each matrix entry is read from and then written back to the per-class totals
// memory before the next one is taken. After the final entry the block emits
// one result per class, computed by the bit-serial dividers, and then the
// memory is cleared, one class per cycle.
// Results appear for one cycle each on result_valid and cannot be stalled.
module confusion_matrix_prf_metrics
	import cmprf_pkg::*;
#(
	parameter int MAX_CLASSES = 16,
	parameter int COUNT_BITS  = 24,
	parameter int FRAC_BITS   = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic [ENTRY_W-1:0]       entry_count,
	input  logic                     cfg_we,
	input  logic [NUM_CLASSES_W-1:0] cfg_wdata,
	output logic                     result_valid,
	output logic [CLASS_W-1:0]       class_index,
	output logic [FRAC_BITS:0]       precision_q16,
	output logic [FRAC_BITS:0]       recall_q16,
	output logic [FRAC_BITS:0]       fmeasure_q16,
	output logic                     last_result
);

	localparam int IDX_W = $clog2(MAX_CLASSES);
	localparam int TOT_W = COUNT_BITS + 6;
	localparam int DEN_W = TOT_W + 1;
	localparam int NUM_W = COUNT_BITS + 1 + FRAC_BITS;
	localparam int WORD_W = 2 * TOT_W + COUNT_BITS;

	state_t state_q;
	logic [NUM_CLASSES_W-1:0] ncls_q;
	logic [IDX_W:0] nact;
	logic [IDX_W-1:0] row_q, col_q, cls_q;
	logic [COUNT_BITS-1:0] val_q;
	logic diag_pend_q;

	// Memory word: {row total, column total, diagonal}.
	logic [WORD_W-1:0] mem [MAX_CLASSES];
	logic [WORD_W-1:0] rd_a_q, rd_b_q;
	logic [IDX_W-1:0] ra, rb;
	logic             we_a, we_b;
	logic [IDX_W-1:0] wa, wb;
	logic [WORD_W-1:0] wd_a, wd_b;

	// Active class count, clipped to 1..MAX_CLASSES.
	always_comb begin
		if (ncls_q == '0)
			nact = (IDX_W+1)'(1);
		else if (ncls_q > NUM_CLASSES_W'(MAX_CLASSES))
			nact = (IDX_W+1)'(MAX_CLASSES);
		else
			nact = ncls_q[IDX_W:0];
	end

	wire last_col = ({1'b0, col_q} + 1'b1) == nact;
	wire last_row = ({1'b0, row_q} + 1'b1) == nact;
	wire last_cls = ({1'b0, cls_q} + 1'b1) == nact;
	wire accept   = start && !busy;

	logic [TOT_W-1:0] a_row, a_col, b_col;
	logic [COUNT_BITS-1:0] a_dg;
	assign a_row = rd_a_q[WORD_W-1 -: TOT_W];
	assign a_col = rd_a_q[COUNT_BITS +: TOT_W];
	assign a_dg  = rd_a_q[COUNT_BITS-1:0];
	assign b_col = rd_b_q[COUNT_BITS +: TOT_W];

	// While loading, port A serves the row class and port B the column class; otherwise port A serves cls_q.
	always_comb begin
		ra = (state_q == ST_LOAD) ? row_q : cls_q;
		rb = col_q;
		we_a = 1'b0; we_b = 1'b0;
		wa = row_q;  wb = col_q;
		wd_a = '0;   wd_b = '0;
		if (state_q == ST_RD) begin
			if (diag_pend_q) begin
				we_a = 1'b1;
				wd_a = {a_row + TOT_W'(val_q), a_col + TOT_W'(val_q), a_dg + val_q};
			end else begin
				we_a = 1'b1;
				wd_a = {a_row + TOT_W'(val_q), a_col, a_dg};
				we_b = 1'b1;
				wd_b = {rd_b_q[WORD_W-1 -: TOT_W], b_col + TOT_W'(val_q),
					rd_b_q[COUNT_BITS-1:0]};
			end
		end else if (state_q == ST_CLR) begin
			we_a = 1'b1;
			wa   = cls_q;
		end
	end

	always_ff @(posedge clk) begin
		if (we_a)
			mem[wa] <= wd_a;
		if (we_b)
			mem[wb] <= wd_b;
		rd_a_q <= mem[ra];
		rd_b_q <= mem[rb];
	end

	// Dividers for the three metrics.
	logic div_go, dp, dr, df;
	logic [FRAC_BITS:0] qp, qr, qf;
	wire [NUM_W-1:0] tp_sh  = NUM_W'(a_dg) << FRAC_BITS;
	wire [NUM_W-1:0] tp2_sh = NUM_W'(a_dg) << (FRAC_BITS + 1);

	cmprf_divider #(.NUM_W(NUM_W), .DEN_W(DEN_W), .Q_W(FRAC_BITS+1)) u_div_p (
		.clk, .arst_n, .go(div_go), .num(tp_sh), .den(DEN_W'(a_col)),
		.done(dp), .quot(qp));
	cmprf_divider #(.NUM_W(NUM_W), .DEN_W(DEN_W), .Q_W(FRAC_BITS+1)) u_div_r (
		.clk, .arst_n, .go(div_go), .num(tp_sh), .den(DEN_W'(a_row)),
		.done(dr), .quot(qr));
	cmprf_divider #(.NUM_W(NUM_W), .DEN_W(DEN_W), .Q_W(FRAC_BITS+1)) u_div_f (
		.clk, .arst_n, .go(div_go), .num(tp2_sh),
		.den(DEN_W'(a_row) + DEN_W'(a_col)), .done(df), .quot(qf));

	logic rd_wait_q;

	// Control sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLR;
			ncls_q       <= NUM_CLASSES_W'(16);
			row_q        <= '0;
			col_q        <= '0;
			cls_q        <= '0;
			diag_pend_q  <= 1'b0;
			result_valid <= 1'b0;
			last_result  <= 1'b0;
			div_go       <= 1'b0;
			rd_wait_q    <= 1'b0;
		end else begin
			result_valid <= 1'b0;
			div_go       <= 1'b0;
			case (state_q)
				ST_LOAD: begin
					if (cfg_we) begin
						ncls_q  <= cfg_wdata;
						cls_q   <= '0;
						state_q <= ST_CLR;
					end else if (accept) begin
						diag_pend_q <= (row_q == col_q);
						state_q     <= ST_RD;
					end
				end
				ST_RD: begin
					if (last_col) begin
						col_q <= '0;
						if (last_row) begin
							row_q     <= '0;
							cls_q     <= '0;
							rd_wait_q <= 1'b1;
							state_q   <= ST_DIV;
						end else begin
							row_q   <= row_q + 1'b1;
							state_q <= ST_LOAD;
						end
					end else begin
						col_q   <= col_q + 1'b1;
						state_q <= ST_LOAD;
					end
				end
				ST_DIV: begin
					// Wait for the registered read of this class, then start the dividers.
					if (rd_wait_q) begin
						rd_wait_q <= 1'b0;
						div_go    <= 1'b1;
					end else if (dp) begin
						result_valid <= 1'b1;
						last_result  <= last_cls;
						state_q      <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (last_cls) begin
						cls_q   <= '0;
						state_q <= ST_CLR;
					end else begin
						cls_q     <= cls_q + 1'b1;
						rd_wait_q <= 1'b1;
						state_q   <= ST_DIV;
					end
				end
				ST_CLR: begin
					if (cfg_we)
						ncls_q <= cfg_wdata;
					if (cls_q == IDX_W'(MAX_CLASSES - 1)) begin
						cls_q   <= '0;
						row_q   <= '0;
						col_q   <= '0;
						state_q <= ST_LOAD;
					end else begin
						cls_q <= cls_q + 1'b1;
					end
				end
				default: state_q <= ST_CLR;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			val_q <= COUNT_BITS'(entry_count);
		if (state_q == ST_DIV && !rd_wait_q && dp) begin
			class_index   <= CLASS_W'(cls_q);
			precision_q16 <= qp;
			recall_q16    <= qr;
			fmeasure_q16  <= qf;
		end
	end

	assign busy = (state_q != ST_LOAD) || cfg_we;

	// The three dividers run in lockstep.
	a_div_sync: assert property (@(posedge clk) disable iff (!arst_n)
		(dp == dr) && (dp == df)) else $error("divider done mismatch");
	// A result only leaves after a divider finishes.
	a_res_src: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(dp)) else $error("result without division");
	// No entry is taken while results are being produced.
	a_no_acc: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV || state_q == ST_OUT) |-> busy) else $error("accept in output");
	// Positions stay within the active matrix while loading.
	a_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LOAD) |-> ({1'b0, row_q} < nact && {1'b0, col_q} < nact))
		else $error("position out of range");

endmodule

[sim/confusion_matrix_prf_metrics_tb.sv]
// Self-checking testbench for confusion_matrix_prf_metrics: loads confusion matrices
// and checks every per-class precision, recall and F-measure beat. Depends on cmprf_pkg.
module confusion_matrix_prf_metrics_tb;
	import cmprf_pkg::*;

	localparam int MAXC       = 16;
	localparam int FRACB      = 16;
	localparam int SETTLE     = 64;
	localparam int WDOG_LIMIT = 5000;
	localparam logic [ENTRY_W-1:0] CNT_MAX = '1;

	typedef struct packed {
		logic [CLASS_W-1:0]  cls;
		logic [METRIC_W-1:0] prec;
		logic [METRIC_W-1:0] rec;
		logic [METRIC_W-1:0] fm;
		logic                last;
	} metric_beat_t;

	// One row of the directed table: a register write or a matrix entry.
	typedef struct {
		bit                  is_cfg;
		logic [ENTRY_W-1:0]  val;
		bit                  typed;
		logic [METRIC_W-1:0] prec;
		logic [METRIC_W-1:0] rec;
		logic [METRIC_W-1:0] fm;
	} stim_row_t;

	logic clk = 0;
	logic arst_n = 0;
	logic start = 0;
	logic busy;
	logic [ENTRY_W-1:0] entry_count = '0;
	logic cfg_we = 0;
	logic [NUM_CLASSES_W-1:0] cfg_wdata = '0;
	logic result_valid;
	logic [CLASS_W-1:0] class_index;
	logic [FRACB:0] precision_q16, recall_q16, fmeasure_q16;
	logic last_result;

	confusion_matrix_prf_metrics DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.entry_count(entry_count), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.result_valid(result_valid), .class_index(class_index),
		.precision_q16(precision_q16), .recall_q16(recall_q16),
		.fmeasure_q16(fmeasure_q16), .last_result(last_result)
	);

	always #4 clk = ~clk;

	// Model of the block's totals.
	logic [6:0]  class_cfg;
	logic [63:0] row_sum [MAXC];
	logic [63:0] col_sum [MAXC];
	logic [63:0] tp_sum  [MAXC];
	int          cur_row, cur_col;

	metric_beat_t pending_metrics[$];
	metric_beat_t fresh_metrics[$];
	int errors = 0;
	int entries_sent = 0;
	int beats_seen = 0;
	int matrices_done = 0;
	int idle_cycles = 0;
	int burst_left = 0;

	function automatic int classes_in_use();
		if (class_cfg == 0) begin
			return 1;
		end
		if (class_cfg > MAXC) begin
			return MAXC;
		end
		return class_cfg;
	endfunction

	function automatic logic [METRIC_W-1:0] ratio_q16(logic [63:0] num, logic [63:0] den);
		if (den == 0) begin
			return '0;
		end
		return METRIC_W'((num << FRACB) / den);
	endfunction

	task automatic clear_totals();
		for (int k = 0; k < MAXC; k++) begin
			row_sum[k] = 0;
			col_sum[k] = 0;
			tp_sum[k] = 0;
		end
		cur_row = 0;
		cur_col = 0;
	endtask

	// Adds one entry to the totals; fills fresh_metrics when the matrix completes.
	task automatic tally_entry(logic [ENTRY_W-1:0] v);
		int n;
		metric_beat_t b;
		n = classes_in_use();
		fresh_metrics.delete();
		if (cur_row >= n || cur_col >= n) begin
			clear_totals();
		end
		row_sum[cur_row] += v;
		col_sum[cur_col] += v;
		if (cur_row == cur_col) begin
			tp_sum[cur_row] += v;
		end
		cur_col++;
		if (cur_col == n) begin
			cur_col = 0;
			cur_row++;
		end
		if (cur_row >= n) begin
			for (int k = 0; k < n; k++) begin
				b.cls  = CLASS_W'(k);
				b.prec = ratio_q16(tp_sum[k], col_sum[k]);
				b.rec  = ratio_q16(tp_sum[k], row_sum[k]);
				b.fm   = ratio_q16(2 * tp_sum[k], row_sum[k] + col_sum[k]);
				b.last = (k + 1 == n);
				fresh_metrics.insert(fresh_metrics.size(), b);
			end
			clear_totals();
			matrices_done++;
		end
	endtask

	// Sends one entry in bursts with random gaps; start stays high inside a burst.
	task automatic send_entry(logic [ENTRY_W-1:0] v);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 6);
			if (gap > 0) begin
				start <= 0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 8);
		end
		start <= 1;
		entry_count <= v;
		do @(posedge clk); while (busy);
		burst_left--;
		entries_sent++;
		tally_entry(v);
	endtask

	// Writes the class count once the block is idle and all beats are in.
	task automatic write_classes(logic [6:0] v);
		start <= 0;
		burst_left = 0;
		wait (pending_metrics.size() == 0);
		repeat (SETTLE) @(posedge clk);
		cfg_we <= 1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 0;
		class_cfg = v;
		clear_totals();
	endtask

	// Result checker: each beat against the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && result_valid) begin
			metric_beat_t e;
			beats_seen++;
			if (pending_metrics.size() == 0) begin
				$display("%0t: unexpected beat class %0d", $time, class_index);
				errors++;
			end else begin
				e = pending_metrics.pop_front();
				if (class_index !== e.cls || precision_q16 !== e.prec
						|| recall_q16 !== e.rec || fmeasure_q16 !== e.fm
						|| last_result !== e.last) begin
					$display("%0t: mismatch exp cls %0d p %0d r %0d f %0d last %0b",
						$time, e.cls, e.prec, e.rec, e.fm, e.last);
					$display("%0t:          got cls %0d p %0d r %0d f %0d last %0b",
						$time, class_index, precision_q16, recall_q16, fmeasure_q16,
						last_result);
					errors++;
				end
			end
		end
	end

	// Watchdog on cycles with no accepted entry or result.
	always @(posedge clk) begin
		if ((start && !busy) || result_valid) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WDOG_LIMIT) begin
			$display("watchdog expired at %0t", $time);
			$display("confusion_matrix_prf_metrics_tb NOT OK");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	stim_row_t dir_rows[$];

	function automatic stim_row_t mk(bit c, logic [ENTRY_W-1:0] v, bit t,
			logic [METRIC_W-1:0] p, logic [METRIC_W-1:0] r, logic [METRIC_W-1:0] f);
		stim_row_t s;
		s.is_cfg = c; s.val = v; s.typed = t; s.prec = p; s.rec = r; s.fm = f;
		return s;
	endfunction

	initial begin
		int n, cnt, pick;
		bit big_done;
		logic [ENTRY_W-1:0] v;
		metric_beat_t b;
		class_cfg = 16;
		clear_totals();
		repeat (7) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed table: single class extremes, zero class count, all-zero
		// diagonal, a small matrix and a partial load abandoned by a write.
		dir_rows.insert(dir_rows.size(), mk(1, 1, 0, 0, 0, 0));
		dir_rows.insert(dir_rows.size(), mk(0, 0, 1, 0, 0, 0));
		dir_rows.insert(dir_rows.size(), mk(0, CNT_MAX, 1, 65536, 65536, 65536));
		dir_rows.insert(dir_rows.size(), mk(1, 0, 0, 0, 0, 0));
		dir_rows.insert(dir_rows.size(), mk(0, 5, 1, 65536, 65536, 65536));
		dir_rows.insert(dir_rows.size(), mk(1, 2, 0, 0, 0, 0));
		dir_rows.insert(dir_rows.size(), mk(0, 0, 0, 0, 0, 0));
		dir_rows.insert(dir_rows.size(), mk(0, CNT_MAX, 0, 0, 0, 0));
		dir_rows.insert(dir_rows.size(), mk(0, CNT_MAX, 0, 0, 0, 0));
		dir_rows.insert(dir_rows.size(), mk(0, 0, 1, 0, 0, 0));
		dir_rows.insert(dir_rows.size(), mk(0, 3, 0, 0, 0, 0));
		dir_rows.insert(dir_rows.size(), mk(0, 1, 0, 0, 0, 0));
		dir_rows.insert(dir_rows.size(), mk(0, 2, 0, 0, 0, 0));
		dir_rows.insert(dir_rows.size(), mk(0, 4, 0, 0, 0, 0));
		dir_rows.insert(dir_rows.size(), mk(0, 7, 0, 0, 0, 0));
		dir_rows.insert(dir_rows.size(), mk(0, 9, 0, 0, 0, 0));
		dir_rows.insert(dir_rows.size(), mk(1, 3, 0, 0, 0, 0));
		for (int i = 0; i < 9; i++) begin
			dir_rows.insert(dir_rows.size(),
				mk(0, (i % 4 == 0) ? CNT_MAX : i, 0, 0, 0, 0));
		end
		foreach (dir_rows[i]) begin
			if (dir_rows[i].is_cfg) begin
				write_classes(dir_rows[i].val[6:0]);
			end else begin
				send_entry(dir_rows[i].val);
				foreach (fresh_metrics[k]) begin
					b = fresh_metrics[k];
					if (dir_rows[i].typed) begin
						b.prec = dir_rows[i].prec;
						b.rec  = dir_rows[i].rec;
						b.fm   = dir_rows[i].fm;
					end
					pending_metrics.insert(pending_metrics.size(), b);
				end
			end
		end

		// Random matrices, mostly small, at most one partial load at the saturated class count.
		big_done = 0;
		while (entries_sent < 150) begin
			pick = $urandom_range(0, 9);
			if (pick == 0 && !big_done) begin
				write_classes($urandom_range(0, 1) ? 7'd127 : 7'd16);
				big_done = 1;
			end else if (pick == 1) begin
				write_classes(7'($urandom_range(0, 1)));
			end else begin
				write_classes(7'($urandom_range(1, 4)));
			end
			n = classes_in_use();
			cnt = ($urandom_range(0, 7) == 0) ? $urandom_range(1, n * n) : n * n;
			// The widest matrix is loaded across one or two row boundaries only.
			if (n == MAXC) begin
				cnt = $urandom_range(MAXC + 1, 2 * MAXC + 8);
			end
			for (int i = 0; i < cnt; i++) begin
				case ($urandom_range(0, 5))
					0: v = 0;
					1: v = CNT_MAX;
					2: v = ENTRY_W'($urandom_range(0, 15));
					default: v = ENTRY_W'($urandom);
				endcase
				send_entry(v);
				foreach (fresh_metrics[k]) begin
					pending_metrics.insert(pending_metrics.size(), fresh_metrics[k]);
				end
			end
		end
		start <= 0;

		wait (pending_metrics.size() == 0);
		repeat (SETTLE) @(posedge clk);
		$display("Sent %0d entries over %0d complete matrices; checked %0d class beats.",
			entries_sent, matrices_done, beats_seen);
		if (errors == 0) begin
			$display("confusion_matrix_prf_metrics_tb OK");
		end else begin
			$display("confusion_matrix_prf_metrics_tb NOT OK");
		end
		$finish;
	end

endmodule

[confusion_matrix_prf_metrics.f]
hw/rtl/cmprf_pkg.sv
hw/rtl/cmprf_divider.sv
hw/rtl/confusion_matrix_prf_metrics.sv
sim/confusion_matrix_prf_metrics_tb.sv
